@@ src/fasm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fasm_pkg;
    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_NONE = 2'd3
    } t_action;
    localparam int FRAC_BITS = 23;
    localparam logic [9:0] EXP_BIAS = 10'd127;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
endpackage
`default_nettype wire

@@ src/float32_add_sub_mul_truncating_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Single-precision add / subtract / multiply, truncating, no rounding.
//
// Usage: drive i_action, i_operand_a, i_operand_b and pulse i_start while
// o_busy is low; the operands are captured in that cycle (one transfer).
// o_busy stays high until the result appears on o_result_bits together
// with a one-cycle o_done strobe. The receiver cannot stall; the result is
// taken in the strobe cycle and the block is ready again the next cycle.
//
// Sequencing: each working magnitude is shifted one place per step in its
// own register, and one shared adder serves both add and multiply. Aligning
// the smaller add operand steps its exponent up once per unit of exponent
// difference (up to 255), although the magnitude stops moving after 31
// places; normalizing takes at most 23 places. A multiply first runs a
// shift-add loop on the same adder, then restores the sign and drops 23
// bits. Action code 3 goes straight to packing. The next transfer is taken
// in the cycle after o_done.
//
// Zero and denormal inputs keep the hidden one. A zero magnitude gives +0.
// The exponent field wraps modulo 256. Action code 3 gives zero.
// Reset (synchronous, active low) returns to idle with no result pending.
module float32_add_sub_mul_truncating_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_operand_a,
    input  wire logic [31:0] i_operand_b,
    output logic             o_busy,
    output logic             o_done,
    output logic [31:0]      o_result_bits
);
    typedef enum logic [2:0] {
        S_IDLE, S_ALIGN, S_MUL, S_MSHIFT, S_ADD, S_NORM, S_PACK
    } t_state;

    t_state       r_state;
    logic [1:0]   r_act;
    logic [9:0]   r_ea, r_eb;        // unbiased exponents, two's complement
    logic [48:0]  r_ma, r_mb;        // signed magnitudes (mb also multiplier)
    logic [48:0]  r_acc;             // signed sum / product
    logic [5:0]   r_cnt;
    logic         r_neg;
    logic [31:0]  r_res;
    logic         r_done;

    // unpack helpers
    logic [48:0] w_ma_in, w_mb_in;
    logic [31:0] w_b_eff;
    always_comb begin
        w_b_eff = (i_action == fasm_pkg::ACT_SUB) ? (i_operand_b ^ fasm_pkg::SIGN_BIT)
                                                  : i_operand_b;
        w_ma_in = {25'd0, 1'b1, i_operand_a[22:0]};
        w_mb_in = {25'd0, 1'b1, w_b_eff[22:0]};
        if (i_operand_a[31]) w_ma_in = -w_ma_in;
        if (w_b_eff[31]) w_mb_in = -w_mb_in;
    end

    // shared adder
    logic [48:0] w_add_x, w_add_y, w_sum;
    always_comb begin
        w_add_x = r_acc;
        w_add_y = r_ma;
        if (r_state == S_ADD) w_add_x = r_mb;
        w_sum = w_add_x + w_add_y;
    end

    logic [9:0] w_ediff;
    assign w_ediff = r_ea - r_eb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    // hold off while the done strobe is still up
                    if (i_start && !r_done) begin
                        r_act <= i_action;
                        r_ea  <= {2'b00, i_operand_a[30:23]} - fasm_pkg::EXP_BIAS;
                        r_eb  <= {2'b00, w_b_eff[30:23]} - fasm_pkg::EXP_BIAS;
                        r_ma  <= w_ma_in;
                        r_mb  <= w_mb_in;
                        r_acc <= '0;
                        r_cnt <= '0;
                        priority case (i_action)
                            fasm_pkg::ACT_MUL:  r_state <= S_MUL;
                            fasm_pkg::ACT_NONE: r_state <= S_PACK;
                            default:            r_state <= S_ALIGN;
                        endcase
                    end
                end
                S_ALIGN: begin
                    // shift smaller operand one place a cycle, saturate at 31
                    if (r_ea == r_eb) begin
                        r_state <= S_ADD;
                    end else if (w_ediff[9]) begin
                        if (r_cnt < 6'd31) r_ma <= {r_ma[48], r_ma[48:1]};
                        r_cnt <= (r_cnt == 6'd31) ? r_cnt : r_cnt + 6'd1;
                        r_ea  <= r_ea + 10'd1;
                    end else begin
                        if (r_cnt < 6'd31) r_mb <= {r_mb[48], r_mb[48:1]};
                        r_cnt <= (r_cnt == 6'd31) ? r_cnt : r_cnt + 6'd1;
                        r_eb  <= r_eb + 10'd1;
                    end
                end
                S_ADD: begin
                    r_acc   <= w_sum;
                    r_state <= S_NORM;
                    r_neg   <= w_sum[48];
                    r_cnt   <= '0;
                end
                S_MUL: begin
                    // radix-2 multiply on |mb| bits, ma sign kept; 24 steps
                    if (r_cnt == 6'd0) begin
                        r_neg <= r_mb[48];
                        if (r_mb[48]) r_mb <= -r_mb;
                        r_cnt <= 6'd1;
                    end else begin
                        if (r_mb[0]) r_acc <= w_sum;
                        r_mb <= {1'b0, r_mb[48:1]};
                        r_ma <= {r_ma[47:0], 1'b0};
                        if (r_cnt == 6'd24) begin
                            r_cnt   <= '0;
                            r_state <= S_MSHIFT;
                        end else begin
                            r_cnt <= r_cnt + 6'd1;
                        end
                    end
                end
                S_MSHIFT: begin
                    // negate if needed, then floor-shift by 23 in one step
                    if (r_cnt == 6'd0) begin
                        if (r_neg) r_acc <= -r_acc;
                        r_cnt <= 6'd1;
                    end else begin
                        r_acc   <= {{23{r_acc[48]}}, r_acc[48:23]};
                        r_neg   <= r_acc[48];
                        r_eb    <= r_ea + r_eb;
                        r_state <= S_NORM;
                        r_cnt   <= '0;
                    end
                end
                S_NORM: begin
                    if (r_acc == '0) begin
                        r_state <= S_PACK;
                    end else if (r_cnt == 6'd0) begin
                        if (r_acc[48]) r_acc <= -r_acc;
                        r_cnt <= 6'd1;
                    end else if (r_acc[47:24] != '0) begin
                        r_acc <= {1'b0, r_acc[48:1]};
                        r_eb  <= r_eb + 10'd1;
                    end else if (!r_acc[23]) begin
                        r_acc <= {r_acc[47:0], 1'b0};
                        r_eb  <= r_eb - 10'd1;
                    end else begin
                        r_state <= S_PACK;
                    end
                end
                S_PACK: begin
                    logic [9:0] v_ef;
                    v_ef = r_eb + fasm_pkg::EXP_BIAS;
                    if (r_act == fasm_pkg::ACT_NONE || r_acc == '0)
                        r_res <= '0;
                    else
                        r_res <= {r_neg, v_ef[7:0], r_acc[22:0]};
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE) || r_done;
    assign o_done        = r_done;
    assign o_result_bits = r_res;
endmodule
`default_nettype wire

@@ src/fasm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fasm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic        o_done,
    input wire logic [31:0] o_result_bits
);
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("done while idle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start not taken");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");
    a_free_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy) else $error("not ready after done");
    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown(o_result_bits)) else $error("result unknown at done");
endmodule
bind float32_add_sub_mul_truncating_unit fasm_checker u_fasm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_result_bits(o_result_bits));
`default_nettype wire
